[rtl/kcc_pkg.sv]
`default_nettype none

package kcc_pkg;

	// Default store depths
	localparam int MAX_PIXELS_DEF    = 4096;
	localparam int MAX_CENTROIDS_DEF = 16;

	// Fixed field widths
	localparam int OP_W      = 2;
	localparam int INDEX_W   = 12;
	localparam int CHAN_W    = 8;
	localparam int CENT_W    = 16;
	localparam int STATUS_W  = 3;
	localparam int LABEL_W   = 4;
	localparam int PCOUNT_W  = 13;
	localparam int CCOUNT_W  = 5;
	localparam int ITER_W    = 8;
	localparam int SEED_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int DIST_W    = 34;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_LOAD       = 2'd0,
		OP_RUN        = 2'd1,
		OP_READ_LABEL = 2'd2,
		OP_READ_CENT  = 2'd3
	} op_t;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RUN_DONE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LABEL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CENT      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_INDEX_ERR = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED   = 2'd3;

	// Linear congruential generator
	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_INC = 32'd12345;

	typedef struct packed {
		op_t               op;
		logic [INDEX_W-1:0] item_index;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
	} req_t;

	typedef struct packed {
		logic [PCOUNT_W-1:0] pixel_count;
		logic [CCOUNT_W-1:0] cluster_count;
		logic [ITER_W-1:0]   iteration_limit;
		logic [SEED_W-1:0]   random_seed;
	} cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LABEL_W-1:0]  label;
		logic [CENT_W-1:0]   centroid_red;
		logic [CENT_W-1:0]   centroid_green;
		logic [CENT_W-1:0]   centroid_blue;
	} res_t;

	function automatic int at_least_one(int v);
		return (v < 1) ? 1 : v;
	endfunction

endpackage

`default_nettype wire

[rtl/kmeans_color_clustering_core.sv]
`default_nettype none
// Load, centroid read, index error: the word is finished straight from the idle state;
// label read: after a label RAM read state. Run: seed picks, then L iterations of assignment
// over N pixels and C clusters and centroid update, D = 29 divider steps (empty clusters skip);
// one squarer and one serial divider serve every pixel and centroid, one item at a time.
// Reset clears control and centroids and sets configuration to defaults; labels read as zero until a run
// writes them, tracked by a fill count, so no clearing pass follows reset.
module kmeans_color_clustering_core
	import kcc_pkg::*;
#(
	parameter int MAX_PIXELS    = MAX_PIXELS_DEF,
	parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [39:0]          s_tdata,   // item_index, red, green, blue
	input  wire logic [7:0]           s_tuser,   // operation
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [55:0]          m_tdata,   // label, centroid_red, _green, _blue
	output logic      [7:0]           m_tuser,   // status
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	cfg_t cfg_q;
	req_t req;
	res_t eng_res;
	res_t out_q;
	logic m_valid_q;
	logic eng_idle;
	logic eng_done;
	logic s_accept;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_count     <= PCOUNT_W'(1);
			cfg_q.cluster_count   <= CCOUNT_W'(1);
			cfg_q.iteration_limit <= '0;
			cfg_q.random_seed     <= SEED_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PIXEL_COUNT:   cfg_q.pixel_count     <= cfg_data[PCOUNT_W-1:0];
				CFG_CLUSTER_COUNT: cfg_q.cluster_count   <= cfg_data[CCOUNT_W-1:0];
				CFG_ITER_LIMIT:    cfg_q.iteration_limit <= cfg_data[ITER_W-1:0];
				CFG_RANDOM_SEED:   cfg_q.random_seed     <= cfg_data[SEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Unpack input word
	assign req.op         = op_t'(s_tuser[OP_W-1:0]);
	assign req.item_index = s_tdata[11:0];
	assign req.red        = s_tdata[19:12];
	assign req.green      = s_tdata[27:20];
	assign req.blue       = s_tdata[35:28];

	// Take a word only when the output register will be free for its result
	assign s_tready = eng_idle && !eng_done && (!m_valid_q || m_tready);
	assign s_accept = s_tvalid && s_tready;

	kcc_engine #(
		.MAX_PIXELS   (MAX_PIXELS),
		.MAX_CENTROIDS(MAX_CENTROIDS)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.start (s_accept),
		.req   (req),
		.cfg   (cfg_q),
		.idle  (eng_idle),
		.done  (eng_done),
		.res   (eng_res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			out_q     <= '0;
		end else if (eng_done) begin
			m_valid_q <= 1'b1;
			out_q     <= eng_res;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = {5'b0, out_q.status};
	assign m_tdata  = {4'b0, out_q.centroid_blue, out_q.centroid_green,
		out_q.centroid_red, out_q.label};

`ifndef ASSERT_OFF
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |-> !m_valid_q)
		else $error("result finished while output register full");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_tready)
		else $error("second word taken while first is in work");

	a_done_shown: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |=> m_tvalid)
		else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

[rtl/kcc_ram.sv]
`default_nettype none

module kcc_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/kcc_divider.sv]
`default_nettype none

module kcc_divider
	import kcc_pkg::*;
#(
	parameter int DVD_W = 29,
	parameter int DVS_W = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic      [DVD_W-1:0] quotient,
	output logic      [DVS_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W+1:0] diff;

	// One restoring step: shift in next dividend bit, try subtract
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DVS_W+1]) begin
				rem_q <= diff[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

[rtl/kcc_engine.sv]
`default_nettype none

module kcc_engine
	import kcc_pkg::*;
#(
	parameter int MAX_PIXELS    = MAX_PIXELS_DEF,
	parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	input  wire cfg_t cfg,
	output logic      idle,
	output logic      done,
	output res_t      res
);

	localparam int PAW    = at_least_one($clog2(MAX_PIXELS));
	localparam int CW     = $clog2(MAX_PIXELS + 1);
	localparam int LW     = at_least_one($clog2(MAX_CENTROIDS));
	localparam int KW     = $clog2(MAX_CENTROIDS + 1);
	localparam int SUM_W  = CHAN_W + CW;
	localparam int DVD_W  = SUM_W + 8;
	localparam int PIX_W  = 3 * CHAN_W;

	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_LREAD     = 13'b0000000000010,
		S_SEED_LCG  = 13'b0000000000100,
		S_SEED_DIV  = 13'b0000000001000,
		S_SEED_WAIT = 13'b0000000010000,
		S_SEED_WR   = 13'b0000000100000,
		S_IT_START  = 13'b0000001000000,
		S_ASN_RD    = 13'b0000010000000,
		S_ASN_CH    = 13'b0000100000000,
		S_ASN_CMP   = 13'b0001000000000,
		S_ASN_WR    = 13'b0010000000000,
		S_UPD_DIV   = 13'b0100000000000,
		S_UPD_WAIT  = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [PAW-1:0]    i_q;
	logic [LW-1:0]     c_q;
	logic [1:0]        ch_q;
	logic [ITER_W-1:0] it_q;
	logic [CW-1:0]     hw_q;
	logic              done_q;
	res_t              res_q;
	logic              lhit_q;
	logic [31:0]       rng_q;
	logic [DIST_W-1:0] acc_q;
	logic [DIST_W-1:0] best_q;
	logic [LW-1:0]     best_c_q;

	logic [CENT_W-1:0] cent_q [MAX_CENTROIDS][3];
	logic [SUM_W-1:0]  sum_q  [MAX_CENTROIDS][3];
	logic [CW-1:0]     cnt_q  [MAX_CENTROIDS];

	logic [CW-1:0]     np;
	logic [KW-1:0]     nc;
	logic [31:0]       idx32;
	logic              last_pix;
	logic              last_c;
	logic [CHAN_W-1:0] pix_ch;
	logic signed [16:0] diff_ch;
	logic signed [33:0] sq;

	logic              pix_we;
	logic              pix_re;
	logic [PAW-1:0]    pix_raddr;
	logic [PIX_W-1:0]  pix_rdata;
	logic              lab_we;
	logic              lab_re;
	logic [LW-1:0]     lab_rdata;

	logic              div_start;
	logic [DVD_W-1:0]  div_dvd;
	logic [CW-1:0]     div_dvs;
	logic              div_busy;
	logic [DVD_W-1:0]  div_quo;
	logic [CW-1:0]     div_rem;

	logic              upd_skip;

	// Clamp counts to legal range
	always_comb begin
		if (cfg.pixel_count == '0) begin
			np = CW'(1);
		end else if (32'(cfg.pixel_count) > 32'(MAX_PIXELS)) begin
			np = CW'(MAX_PIXELS);
		end else begin
			np = CW'(cfg.pixel_count);
		end
		if (cfg.cluster_count == '0) begin
			nc = KW'(1);
		end else if (32'(cfg.cluster_count) > 32'(MAX_CENTROIDS)) begin
			nc = KW'(MAX_CENTROIDS);
		end else begin
			nc = KW'(cfg.cluster_count);
		end
	end

	assign idx32    = 32'(req.item_index);
	assign last_pix = (CW'(i_q) == np - 1'b1);
	assign last_c   = (KW'(c_q) == nc - 1'b1);

	// Squared channel distance: Q8.8 difference, Q16.16 square
	always_comb begin
		case (ch_q)
			2'd0:    pix_ch = pix_rdata[CHAN_W-1:0];
			2'd1:    pix_ch = pix_rdata[2*CHAN_W-1:CHAN_W];
			default: pix_ch = pix_rdata[3*CHAN_W-1:2*CHAN_W];
		endcase
		diff_ch = $signed({1'b0, pix_ch, 8'b0}) - $signed({1'b0, cent_q[c_q][ch_q]});
		sq      = diff_ch * diff_ch;
	end

	// Memory controls
	assign pix_we    = (state_q == S_IDLE) && start && (req.op == OP_LOAD) &&
		(idx32 < 32'(MAX_PIXELS));
	assign pix_re    = ((state_q == S_SEED_WAIT) && !div_busy) || (state_q == S_ASN_RD);
	assign pix_raddr = (state_q == S_SEED_WAIT) ? div_rem[PAW-1:0] : i_q;
	assign lab_we    = (state_q == S_ASN_WR);
	assign lab_re    = (state_q == S_IDLE) && start && (req.op == OP_READ_LABEL);

	kcc_ram #(
		.DATA_W(PIX_W),
		.DEPTH (MAX_PIXELS),
		.ADDR_W(PAW)
	) u_pixels (
		.clk  (clk),
		.we   (pix_we),
		.waddr(idx32[PAW-1:0]),
		.wdata({req.blue, req.green, req.red}),
		.re   (pix_re),
		.raddr(pix_raddr),
		.rdata(pix_rdata)
	);

	kcc_ram #(
		.DATA_W(LW),
		.DEPTH (MAX_PIXELS),
		.ADDR_W(PAW)
	) u_labels (
		.clk  (clk),
		.we   (lab_we),
		.waddr(i_q),
		.wdata(best_c_q),
		.re   (lab_re),
		.raddr(idx32[PAW-1:0]),
		.rdata(lab_rdata)
	);

	// Shared divider: seed pick modulo and centroid means
	assign upd_skip  = (cnt_q[c_q] == '0);
	assign div_start = (state_q == S_SEED_DIV) || ((state_q == S_UPD_DIV) && !upd_skip);
	assign div_dvd   = (state_q == S_SEED_DIV) ? DVD_W'(rng_q[30:16])
		: {sum_q[c_q][ch_q], 8'b0};
	assign div_dvs   = (state_q == S_SEED_DIV) ? np : cnt_q[c_q];

	kcc_divider #(
		.DVD_W(DVD_W),
		.DVS_W(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Per-cluster sums, cleared at each iteration start
	always_ff @(posedge clk) begin
		if (state_q == S_IT_START) begin
			for (int k = 0; k < MAX_CENTROIDS; k++) begin
				cnt_q[k] <= '0;
				for (int j = 0; j < 3; j++) begin
					sum_q[k][j] <= '0;
				end
			end
		end else if (state_q == S_ASN_WR) begin
			cnt_q[best_c_q]    <= cnt_q[best_c_q] + 1'b1;
			sum_q[best_c_q][0] <= sum_q[best_c_q][0] + SUM_W'(pix_rdata[CHAN_W-1:0]);
			sum_q[best_c_q][1] <= sum_q[best_c_q][1] + SUM_W'(pix_rdata[2*CHAN_W-1:CHAN_W]);
			sum_q[best_c_q][2] <= sum_q[best_c_q][2] +
				SUM_W'(pix_rdata[3*CHAN_W-1:2*CHAN_W]);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			i_q      <= '0;
			c_q      <= '0;
			ch_q     <= '0;
			it_q     <= '0;
			hw_q     <= '0;
			res_q    <= '0;
			lhit_q   <= 1'b0;
			rng_q    <= '0;
			acc_q    <= '0;
			best_q   <= '0;
			best_c_q <= '0;
			for (int k = 0; k < MAX_CENTROIDS; k++) begin
				for (int j = 0; j < 3; j++) begin
					cent_q[k][j] <= '0;
				end
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						res_q <= '0;
						case (req.op)
							OP_LOAD: begin
								res_q.status <= (idx32 < 32'(MAX_PIXELS)) ? ST_LOADED
									: ST_INDEX_ERR;
								done_q <= 1'b1;
							end
							OP_RUN: begin
								rng_q   <= cfg.random_seed;
								c_q     <= '0;
								state_q <= S_SEED_LCG;
							end
							OP_READ_LABEL: begin
								if (idx32 < 32'(np)) begin
									lhit_q  <= (idx32 < 32'(hw_q));
									state_q <= S_LREAD;
								end else begin
									res_q.status <= ST_INDEX_ERR;
									done_q       <= 1'b1;
								end
							end
							default: begin
								if (idx32 < 32'(nc)) begin
									res_q.status         <= ST_CENT;
									res_q.centroid_red   <= cent_q[idx32[LW-1:0]][0];
									res_q.centroid_green <= cent_q[idx32[LW-1:0]][1];
									res_q.centroid_blue  <= cent_q[idx32[LW-1:0]][2];
								end else begin
									res_q.status <= ST_INDEX_ERR;
								end
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_LREAD: begin
					res_q.status <= ST_LABEL;
					res_q.label  <= lhit_q ? LABEL_W'(lab_rdata) : '0;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_SEED_LCG: begin
					rng_q   <= rng_q * LCG_MUL + LCG_INC;
					state_q <= S_SEED_DIV;
				end
				S_SEED_DIV: begin
					state_q <= S_SEED_WAIT;
				end
				S_SEED_WAIT: begin
					if (!div_busy) begin
						state_q <= S_SEED_WR;
					end
				end
				S_SEED_WR: begin
					cent_q[c_q][0] <= {pix_rdata[CHAN_W-1:0], 8'b0};
					cent_q[c_q][1] <= {pix_rdata[2*CHAN_W-1:CHAN_W], 8'b0};
					cent_q[c_q][2] <= {pix_rdata[3*CHAN_W-1:2*CHAN_W], 8'b0};
					if (!last_c) begin
						c_q     <= c_q + 1'b1;
						state_q <= S_SEED_LCG;
					end else if (cfg.iteration_limit == '0) begin
						res_q.status <= ST_RUN_DONE;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						it_q    <= '0;
						state_q <= S_IT_START;
					end
				end
				S_IT_START: begin
					i_q     <= '0;
					state_q <= S_ASN_RD;
				end
				S_ASN_RD: begin
					c_q     <= '0;
					ch_q    <= '0;
					acc_q   <= '0;
					state_q <= S_ASN_CH;
				end
				S_ASN_CH: begin
					acc_q <= acc_q + DIST_W'(unsigned'(sq));
					if (ch_q == 2'd2) begin
						state_q <= S_ASN_CMP;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				S_ASN_CMP: begin
					// Lowest index wins ties
					if (c_q == '0 || acc_q < best_q) begin
						best_q   <= acc_q;
						best_c_q <= c_q;
					end
					if (last_c) begin
						state_q <= S_ASN_WR;
					end else begin
						c_q     <= c_q + 1'b1;
						ch_q    <= '0;
						acc_q   <= '0;
						state_q <= S_ASN_CH;
					end
				end
				S_ASN_WR: begin
					if (last_pix) begin
						if (np > hw_q) begin
							hw_q <= np;
						end
						c_q     <= '0;
						ch_q    <= '0;
						state_q <= S_UPD_DIV;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_ASN_RD;
					end
				end
				S_UPD_DIV, S_UPD_WAIT: begin
					if (state_q == S_UPD_DIV && !upd_skip) begin
						state_q <= S_UPD_WAIT;
					end else if (state_q == S_UPD_WAIT && div_busy) begin
						state_q <= S_UPD_WAIT;
					end else begin
						if (state_q == S_UPD_WAIT) begin
							cent_q[c_q][ch_q] <= div_quo[CENT_W-1:0];
						end
						// Advance channel, cluster, then iteration
						if (ch_q != 2'd2 && !upd_skip) begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_UPD_DIV;
						end else if (!last_c) begin
							ch_q    <= '0;
							c_q     <= c_q + 1'b1;
							state_q <= S_UPD_DIV;
						end else if (ITER_W'(it_q + 1'b1) == cfg.iteration_limit) begin
							res_q.status <= ST_RUN_DONE;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							it_q    <= it_q + 1'b1;
							state_q <= S_IT_START;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

[tb/sv/kmeans_color_clustering_core_test.sv]
`timescale 1ns / 1ps

module kmeans_color_clustering_core_test;
	import kcc_pkg::*;

	localparam int NPIX = MAX_PIXELS_DEF;
	localparam int NCEN = MAX_CENTROIDS_DEF;

	typedef struct {
		op_t         op;
		logic [11:0] idx;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
	} pixel_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [7:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [7:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	kmeans_color_clustering_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Mirror of the block state
	logic [12:0] km_pixel_count = 13'd1;
	logic [4:0]  km_cluster_count = 5'd1;
	logic [7:0]  km_iter_limit = 8'd0;
	logic [31:0] km_seed = 32'd1;
	logic [7:0]  km_pix [0:NPIX-1][0:2];
	logic [3:0]  km_label [0:NPIX-1];
	logic [15:0] km_cent [0:NCEN-1][0:2];

	pixel_req_t pending_items[$];
	res_t       expected_words[$];
	int         errors = 0;
	int         words_seen = 0;
	int         runs_seen = 0;
	int         index_errs = 0;
	int         items_sent = 0;

	function automatic int eff_pixels();
		if (km_pixel_count < 1) return 1;
		if (km_pixel_count > NPIX) return NPIX;
		return km_pixel_count;
	endfunction

	function automatic int eff_clusters();
		if (km_cluster_count < 1) return 1;
		if (km_cluster_count > NCEN) return NCEN;
		return km_cluster_count;
	endfunction

	// Seed, pick initial centroids, then run the Lloyd iterations
	function automatic void cluster_pixels();
		int np, nc, pick;
		logic [31:0] lcg;
		longint d;
		longint unsigned sq_dist, best_dist;
		int best;
		longint unsigned sums [0:NCEN-1][0:2];
		longint unsigned cnt [0:NCEN-1];
		np = eff_pixels();
		nc = eff_clusters();
		lcg = km_seed;
		for (int c = 0; c < nc; c++) begin
			lcg = lcg * LCG_MUL + LCG_INC;
			pick = int'(((lcg >> 16) & 32'h7FFF) % np);
			for (int ch = 0; ch < 3; ch++) km_cent[c][ch] = {km_pix[pick][ch], 8'd0};
		end
		for (int it = 0; it < km_iter_limit; it++) begin
			for (int i = 0; i < np; i++) begin
				best = 0;
				best_dist = 0;
				for (int c = 0; c < nc; c++) begin
					sq_dist = 0;
					for (int ch = 0; ch < 3; ch++) begin
						d = longint'({km_pix[i][ch], 8'd0}) - longint'(km_cent[c][ch]);
						sq_dist += d * d;
					end
					if (c == 0 || sq_dist < best_dist) begin
						best_dist = sq_dist;
						best = c;
					end
				end
				km_label[i] = 4'(best);
			end
			for (int c = 0; c < NCEN; c++) begin
				cnt[c] = 0;
				for (int ch = 0; ch < 3; ch++) sums[c][ch] = 0;
			end
			for (int i = 0; i < np; i++) begin
				for (int ch = 0; ch < 3; ch++) sums[km_label[i]][ch] += km_pix[i][ch];
				cnt[km_label[i]]++;
			end
			for (int c = 0; c < nc; c++)
				if (cnt[c] != 0)
					for (int ch = 0; ch < 3; ch++)
						km_cent[c][ch] = 16'(((sums[c][ch] << 8) / cnt[c]) & 16'hFFFF);
		end
	endfunction

	function automatic res_t cluster_predict(pixel_req_t it);
		res_t w;
		w = '0;
		case (it.op)
			OP_LOAD: begin
				km_pix[it.idx][0] = it.r;
				km_pix[it.idx][1] = it.g;
				km_pix[it.idx][2] = it.b;
				w.status = ST_LOADED;
			end
			OP_RUN: begin
				cluster_pixels();
				w.status = ST_RUN_DONE;
			end
			OP_READ_LABEL: begin
				if (it.idx >= eff_pixels()) w.status = ST_INDEX_ERR;
				else begin
					w.status = ST_LABEL;
					w.label = km_label[it.idx];
				end
			end
			default: begin
				if (it.idx >= eff_clusters()) w.status = ST_INDEX_ERR;
				else begin
					w.status = ST_CENT;
					w.centroid_red = km_cent[it.idx][0];
					w.centroid_green = km_cent[it.idx][1];
					w.centroid_blue = km_cent[it.idx][2];
				end
			end
		endcase
		return w;
	endfunction

	// Clock and reset
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: bursts of words with random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk) begin
		pixel_req_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				nxt.op = op_t'(s_tuser[1:0]);
				nxt.idx = s_tdata[11:0];
				nxt.r = s_tdata[19:12];
				nxt.g = s_tdata[27:20];
				nxt.b = s_tdata[35:28];
				expected_words.push_back(cluster_predict(nxt));
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					nxt = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= {6'd0, nxt.op};
					s_tdata <= {4'd0, nxt.b, nxt.g, nxt.r, nxt.idx};
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
					end else
						burst_left <= burst_left - 1;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stall pattern chosen from three modes, one long hold-off
	int rx_mode = 0;
	int rx_cycle = 0;
	int hold_cnt = 0;
	bit held = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 50 == 0) rx_mode <= $urandom_range(0, 2);
			if (!held && words_seen >= 20) begin
				held <= 1'b1;
				hold_cnt <= 400;
				m_tready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Monitor: compare each word with the oldest expectation
	always @(posedge clk) begin
		res_t exp_w, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser[2:0];
			got.label = m_tdata[3:0];
			got.centroid_red = m_tdata[19:4];
			got.centroid_green = m_tdata[35:20];
			got.centroid_blue = m_tdata[51:36];
			words_seen++;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, actual %p", $time, got);
				errors++;
			end else begin
				exp_w = expected_words.pop_front();
				if (got.status == ST_RUN_DONE) runs_seen++;
				if (got.status == ST_INDEX_ERR) index_errs++;
				if (got !== exp_w) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, exp_w, got);
					errors++;
				end
			end
		end
	end

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_words.size() != 0);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_PIXEL_COUNT:   km_pixel_count = val[12:0];
			CFG_CLUSTER_COUNT: km_cluster_count = val[4:0];
			CFG_ITER_LIMIT:    km_iter_limit = val[7:0];
			default:           km_seed = val;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_item(op_t op, int idx, int r, int g, int b);
		pixel_req_t it;
		it.op = op;
		it.idx = 12'(idx);
		it.r = 8'(r);
		it.g = 8'(g);
		it.b = 8'(b);
		pending_items.push_back(it);
	endtask

	// One phase: configure, load the used pixels, run, read back
	task automatic cluster_phase(int np, int nc, int iters, logic [31:0] seed, int reads,
			bit junk);
		int base [0:3][0:2];
		int k, np_eff;
		wait_idle();
		cfg_write(CFG_PIXEL_COUNT, junk ? 32'({$urandom, 13'd0} | np) : 32'(np));
		cfg_write(CFG_CLUSTER_COUNT, junk ? 32'({$urandom, 5'd0} | nc) : 32'(nc));
		cfg_write(CFG_ITER_LIMIT, junk ? 32'({$urandom, 8'd0} | iters) : 32'(iters));
		cfg_write(CFG_RANDOM_SEED, seed);
		np_eff = eff_pixels();
		for (int j = 0; j < 4; j++)
			for (int ch = 0; ch < 3; ch++) base[j][ch] = $urandom_range(20, 235);
		for (int i = 0; i < np_eff; i++) begin
			if ($urandom_range(0, 1)) begin
				k = $urandom_range(0, 3);
				queue_item(OP_LOAD, i, base[k][0] + $urandom_range(0, 40) - 20,
					base[k][1] + $urandom_range(0, 40) - 20,
					base[k][2] + $urandom_range(0, 40) - 20);
			end else
				queue_item(OP_LOAD, i, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
		end
		queue_item(OP_RUN, $urandom_range(0, 4095), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255));
		for (int i = 0; i < reads; i++) begin
			k = $urandom_range(0, 19);
			if (k < 9)
				queue_item(OP_READ_LABEL, (k < 8) ? $urandom_range(0, np_eff - 1)
					: $urandom_range(0, 4095), 0, 0, 0);
			else if (k < 18)
				queue_item(OP_READ_CENT, (k < 17) ? $urandom_range(0, 15)
					: $urandom_range(0, 4095), 0, 0, 0);
			else
				queue_item(OP_LOAD, $urandom_range(np_eff, 4095), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255));
		end
		// rerun on the same data now and then
		if ($urandom_range(0, 2) == 0) begin
			queue_item(OP_RUN, 0, 0, 0, 0);
			queue_item(OP_READ_CENT, 0, 0, 0, 0);
			queue_item(OP_READ_LABEL, np_eff - 1, 0, 0, 0);
		end
	endtask

	// Stimulus
	initial begin
		int np;
		// mirror starts from the reset contents
		for (int i = 0; i < NPIX; i++) begin
			km_label[i] = 4'd0;
			for (int ch = 0; ch < 3; ch++) km_pix[i][ch] = 8'd0;
		end
		for (int c = 0; c < NCEN; c++)
			for (int ch = 0; ch < 3; ch++) km_cent[c][ch] = 16'd0;
		@(posedge arst_n);
		// directed: reads before any run, index errors, channel extremes
		queue_item(OP_READ_LABEL, 0, 0, 0, 0);
		queue_item(OP_READ_LABEL, 1, 0, 0, 0);
		queue_item(OP_READ_LABEL, 4095, 255, 255, 255);
		queue_item(OP_READ_CENT, 0, 0, 0, 0);
		queue_item(OP_READ_CENT, 1, 0, 0, 0);
		queue_item(OP_READ_CENT, 4095, 0, 0, 0);
		queue_item(OP_LOAD, 0, 255, 0, 255);
		queue_item(OP_LOAD, 4095, 0, 255, 0);
		queue_item(OP_LOAD, 0, 255, 255, 255);
		queue_item(OP_RUN, 0, 0, 0, 0);
		queue_item(OP_READ_CENT, 0, 0, 0, 0);
		queue_item(OP_READ_LABEL, 0, 0, 0, 0);
		queue_item(OP_LOAD, 1, 0, 0, 0);
		queue_item(OP_LOAD, 2, 128, 64, 32);
		queue_item(OP_READ_LABEL, 4095, 0, 0, 0);
		queue_item(OP_RUN, 4095, 0, 0, 0);
		queue_item(OP_READ_CENT, 0, 0, 0, 0);
		for (int i = 0; i < 10; i++)
			queue_item(OP_READ_CENT, 0, $urandom_range(0, 255), 0, 0);
		// extremes of the registers
		cluster_phase(0, 0, 0, 32'd0, 8, 1'b0);
		cluster_phase(5, 2, 255, 32'hFFFF_FFFF, 12, 1'b0);
		cluster_phase(6, 31, 3, $urandom, 20, 1'b0);
		cluster_phase(64, 16, 1, $urandom, 40, 1'b0);
		// random settings, small sizes
		for (int p = 0; p < 5; p++) begin
			np = $urandom_range(1, 40);
			cluster_phase(np, $urandom_range(1, 16), $urandom_range(0, 8), $urandom,
				$urandom_range(20, 40), $urandom_range(0, 1));
		end
		wait_idle();
		repeat (50) @(posedge clk);
		$display("Covered %0d items, %0d clustering runs, %0d index errors,", items_sent,
			runs_seen, index_errs);
		$display("register extremes, clamped counts, stalls and a long receiver hold-off.");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
